@@ rtl/core/lmfe_pkg.sv @@
// Shared types and constants of the line marker file name extractor.
`default_nettype none

package lmfe_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  char_value;
      logic        name_changed;
      logic [12:0] name_length;
   } rsp_type;

   // Result kinds
   localparam logic [2:0] KIND_BYTE    = 3'd0;
   localparam logic [2:0] KIND_END     = 3'd1;
   localparam logic [2:0] KIND_FULL    = 3'd2;
   localparam logic [2:0] KIND_DONE    = 3'd3;
   localparam logic [2:0] KIND_BAD_ESC = 3'd4;

   // Work handed from the parser to the compare stage
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_START   = 3'd1,
      OP_STORE   = 3'd2,
      OP_END     = 3'd3,
      OP_FULL    = 3'd4,
      OP_DONE    = 3'd5,
      OP_BAD_ESC = 3'd6
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_value;
   } stage_type;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_LO_E  = 8'h65;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_I  = 8'h69;
   localparam logic [7:0] CH_LO_L  = 8'h6c;
   localparam logic [7:0] CH_LO_N  = 8'h6e;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_LO_T  = 8'h74;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   // Result queue
   localparam int OUT_DEPTH = 4;

endpackage

`default_nettype wire

@@ rtl/core/lmfe_name_ram.sv @@
// Two-bank name store: one write port, one registered read port.
`default_nettype none

module lmfe_name_ram #(
   parameter int AW = 14
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data_ff
);

   logic [7:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/lmfe_parser.sv @@
// Byte-level line marker parser; issues name store writes and compare reads.
`default_nettype none

module lmfe_parser
   import lmfe_pkg::*;
#(
   parameter int NAME_BUFFER_BYTES = 8192,
   parameter int IW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire req_type       req,
   input  wire logic          bank_select,
   output stage_type          stage_ff,
   output logic [IW-1:0]      index_ff,
   output logic               wr_en,
   output logic [IW:0]        wr_addr,
   output logic [7:0]         wr_data,
   output logic [IW:0]        rd_addr
);

   typedef enum logic [11:0] {
      S_LEAD     = 12'b0000_0000_0001,
      S_HASH     = 12'b0000_0000_0010,
      S_KW_I     = 12'b0000_0000_0100,
      S_KW_N     = 12'b0000_0000_1000,
      S_KW_E     = 12'b0000_0001_0000,
      S_KW_GAP   = 12'b0000_0010_0000,
      S_LINE_GAP = 12'b0000_0100_0000,
      S_NUMBER   = 12'b0000_1000_0000,
      S_NUM_GAP  = 12'b0001_0000_0000,
      S_NAME     = 12'b0010_0000_0000,
      S_ESC      = 12'b0100_0000_0000,
      S_SKIP     = 12'b1000_0000_0000
   } mode_type;

   localparam logic [IW-1:0] FULL_AT = IW'(NAME_BUFFER_BYTES - 1);

   mode_type      mode_ff, mode_in;
   logic [IW-1:0] count_ff, count_in;
   stage_type     stage_in;
   logic [IW-1:0] index_in;
   logic [7:0]    c;
   logic          blank, digit, hex, eol;
   mode_type      skip_mode;

   assign c     = req.data_byte;
   assign blank = (c == CH_SPACE) || (c == CH_TAB);
   assign digit = c inside {[CH_0:CH_9]};
   assign hex   = c inside {[CH_0:CH_9], [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
   assign eol   = (c == CH_CR) || (c == CH_LF);
   assign skip_mode = eol ? S_LEAD : S_SKIP;

   always_comb begin
      mode_in             = mode_ff;
      count_in            = count_ff;
      stage_in.op         = OP_NONE;
      stage_in.char_value = c;
      index_in            = count_ff;
      wr_en               = 1'b0;
      wr_data             = c;
      if (accept) begin
         if (req.end_of_input) begin
            mode_in     = S_LEAD;
            count_in    = '0;
            stage_in.op = OP_DONE;
         end else begin
            case (mode_ff)
               S_LEAD: begin
                  if (!blank) begin
                     mode_in = (c == CH_HASH) ? S_HASH : skip_mode;
                  end
               end
               S_HASH: begin
                  if (!blank) begin
                     if (c == CH_LO_L) begin
                        mode_in = S_KW_I;
                     end else if (digit) begin
                        mode_in = S_NUMBER;
                     end else begin
                        mode_in = skip_mode;
                     end
                  end
               end
               S_KW_I:   mode_in = (c == CH_LO_I) ? S_KW_N : S_SKIP;
               S_KW_N:   mode_in = (c == CH_LO_N) ? S_KW_E : S_SKIP;
               S_KW_E:   mode_in = (c == CH_LO_E) ? S_KW_GAP : S_SKIP;
               S_KW_GAP: mode_in = blank ? S_LINE_GAP : S_SKIP;
               S_LINE_GAP: begin
                  if (!blank) begin
                     mode_in = digit ? S_NUMBER : skip_mode;
                  end
               end
               S_NUMBER: begin
                  if (!hex) begin
                     mode_in = blank ? S_NUM_GAP : skip_mode;
                  end
               end
               S_NUM_GAP: begin
                  if (!blank) begin
                     if (c == CH_QUOTE) begin
                        mode_in     = S_NAME;
                        count_in    = '0;
                        stage_in.op = OP_START;
                     end else begin
                        mode_in = skip_mode;
                     end
                  end
               end
               S_NAME: begin
                  if (count_ff >= FULL_AT) begin
                     mode_in     = skip_mode;
                     stage_in.op = OP_FULL;
                  end else if (c == CH_BSL) begin
                     mode_in = S_ESC;
                  end else if (c == CH_QUOTE) begin
                     mode_in     = S_SKIP;
                     stage_in.op = OP_END;
                  end else begin
                     stage_in.op = OP_STORE;
                     wr_en       = 1'b1;
                     count_in    = count_ff + 1'b1;
                  end
               end
               S_ESC: begin
                  mode_in     = S_NAME;
                  stage_in.op = OP_STORE;
                  wr_en       = 1'b1;
                  count_in    = count_ff + 1'b1;
                  case (c)
                     CH_BSL:  wr_data = CH_SLASH;
                     CH_LO_T: wr_data = CH_TAB;
                     CH_LO_R: wr_data = CH_CR;
                     CH_LO_N: wr_data = CH_LF;
                     CH_LO_B: wr_data = CH_BS;
                     default: begin
                        // drop the byte and report it
                        stage_in.op = OP_BAD_ESC;
                        wr_en       = 1'b0;
                        count_in    = count_ff;
                     end
                  endcase
                  if (wr_en) begin
                     stage_in.char_value = wr_data;
                  end
               end
               S_SKIP: begin
                  if (eol) begin
                     mode_in = S_LEAD;
                  end
               end
               default: mode_in = skip_mode;
            endcase
         end
      end
   end

   // Write the bank not holding the previous name; read the previous one.
   assign wr_addr = {~bank_select, count_ff};
   assign rd_addr = {bank_select, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= S_LEAD;
         count_ff    <= '0;
         stage_ff.op <= OP_NONE;
      end else begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         stage_ff.op <= stage_in.op;
      end
      stage_ff.char_value <= stage_in.char_value;
      index_ff            <= index_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/lmfe_compare.sv @@
// Compare stage: checks each stored byte against the previous name, forms results.
`default_nettype none

module lmfe_compare
   import lmfe_pkg::*;
#(
   parameter int IW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_type     stage,
   input  wire logic [IW-1:0] index,
   input  wire logic [7:0]    rd_data,
   output logic               push,
   output rsp_type            rsp,
   output logic               bank_select
);

   logic          differs_ff, differs_in;
   logic          have_prev_ff, have_prev_in;
   logic [IW-1:0] prev_len_ff, prev_len_in;
   logic          bank_ff, bank_in;
   logic          changed;

   assign changed = !have_prev_ff || (prev_len_ff != index) || differs_ff;

   always_comb begin
      differs_in       = differs_ff;
      have_prev_in     = have_prev_ff;
      prev_len_in      = prev_len_ff;
      bank_in          = bank_ff;
      push             = 1'b0;
      rsp.kind         = KIND_BYTE;
      rsp.char_value   = '0;
      rsp.name_changed = 1'b0;
      rsp.name_length  = '0;
      case (stage.op)
         OP_START: differs_in = 1'b0;
         OP_STORE: begin
            push           = 1'b1;
            rsp.char_value = stage.char_value;
            if (!(have_prev_ff && (index < prev_len_ff)) || (rd_data != stage.char_value)) begin
               differs_in = 1'b1;
            end
         end
         OP_END: begin
            push             = 1'b1;
            rsp.kind         = KIND_END;
            rsp.name_changed = changed;
            rsp.name_length  = 13'(index);
            if (changed) begin
               bank_in      = ~bank_ff;
               prev_len_in  = index;
               have_prev_in = 1'b1;
            end
         end
         OP_FULL: begin
            push     = 1'b1;
            rsp.kind = KIND_FULL;
         end
         OP_DONE: begin
            push         = 1'b1;
            rsp.kind     = KIND_DONE;
            differs_in   = 1'b0;
            have_prev_in = 1'b0;
            prev_len_in  = '0;
         end
         OP_BAD_ESC: begin
            push           = 1'b1;
            rsp.kind       = KIND_BAD_ESC;
            rsp.char_value = stage.char_value;
         end
         default: ;
      endcase
   end

   assign bank_select = bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         differs_ff   <= 1'b0;
         have_prev_ff <= 1'b0;
         prev_len_ff  <= '0;
         bank_ff      <= 1'b0;
      end else begin
         differs_ff   <= differs_in;
         have_prev_ff <= have_prev_in;
         prev_len_ff  <= prev_len_in;
         bank_ff      <= bank_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lmfe_out_fifo.sv @@
// Small result queue between the compare stage and the rsp channel.
`default_nettype none

module lmfe_out_fifo
   import lmfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire rsp_type    push_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   output logic [$clog2(OUT_DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(OUT_DEPTH);
   localparam int CW = $clog2(OUT_DEPTH + 1);

   rsp_type       slot_ff [OUT_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/line_marker_filename_extractor.sv @@
// Path: an accepted byte passes the parser stage register and the name RAM read register;
// the compare stage then writes its result into the result queue, which raises rsp_valid.
// Throughput: one byte per cycle, one name RAM write and read per name byte;
// req_ready drops only while the result queue cannot take the results in flight.
// Reset: synchronous, active high; clears parser, compare state and result queue.
// The name RAM is not cleared and needs no clearing pass.
`default_nettype none

module line_marker_filename_extractor
   import lmfe_pkg::*;
#(
   parameter int NAME_BUFFER_BYTES = 8192
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data
);

   localparam int IW = $clog2(NAME_BUFFER_BYTES);
   localparam int CW = $clog2(OUT_DEPTH + 1);

   logic          accept;
   logic          bank_select;
   stage_type     stage;
   logic [IW-1:0] index;
   logic          wr_en;
   logic [IW:0]   wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic          push;
   rsp_type       push_data;
   logic [CW-1:0] fifo_count;
   logic [CW:0]   reserved;

   // Reserve a queue slot for the item in the compare stage and the new one.
   assign reserved  = {1'b0, fifo_count} + (CW+1)'(stage.op != OP_NONE);
   assign req_ready = (reserved < (CW+1)'(OUT_DEPTH));
   assign accept    = req_valid && req_ready;

   lmfe_parser #(
      .NAME_BUFFER_BYTES(NAME_BUFFER_BYTES),
      .IW(IW)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .bank_select(bank_select),
      .stage_ff(stage),
      .index_ff(index),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr)
   );

   lmfe_name_ram #(
      .AW(IW + 1)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data_ff(rd_data)
   );

   lmfe_compare #(
      .IW(IW)
   ) u_compare (
      .clock(clock),
      .reset(reset),
      .stage(stage),
      .index(index),
      .rd_data(rd_data),
      .push(push),
      .rsp(push_data),
      .bank_select(bank_select)
   );

   lmfe_out_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .count(fifo_count)
   );

endmodule

`default_nettype wire

@@ rtl/core/lmfe_checker.sv @@
// Port-level checks on the extractor and their binding to the top level.
`default_nettype none

module lmfe_checker
   import lmfe_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind == KIND_BYTE) || (rsp_data.kind == KIND_END) ||
                    (rsp_data.kind == KIND_FULL) || (rsp_data.kind == KIND_DONE) ||
                    (rsp_data.kind == KIND_BAD_ESC))
      else $error("bad result kind");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_END) |->
         !rsp_data.name_changed && (rsp_data.name_length == '0))
      else $error("name end fields set on another kind");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.kind == KIND_DONE) || (rsp_data.kind == KIND_FULL)) |->
         (rsp_data.char_value == '0))
      else $error("char on done or full result");

endmodule

bind line_marker_filename_extractor lmfe_checker u_lmfe_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);

`default_nettype wire
